// File: design/cbm_pkg.sv
// Shared types, codes and address constants for the cartridge bank mapper.
package cbm_pkg;

  localparam int unsigned PRG_SLOTS   = 4;
  localparam int unsigned CHR_SLOTS   = 8;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned BANK_W      = 8;

  // CPU register map
  localparam logic [15:0] ADDR_PRG_BASE   = 16'h8000;
  localparam logic [15:0] ADDR_PRG_MASK   = 16'h0003;
  localparam logic [15:0] ADDR_CHR_BASE   = 16'hA000;
  localparam logic [15:0] ADDR_CHR_MASK   = 16'h0007;
  localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_ACK    = 16'hC002;
  localparam logic [15:0] ADDR_IRQ_LOAD   = 16'hC003;
  localparam logic [15:0] ADDR_MIRROR     = 16'hD000;
  localparam logic [15:0] ADDR_IRQ_EN     = 16'hE000;

  localparam logic [1:0]  IRQ_DELAY_ARM   = 2'd2;
  localparam logic [7:0]  LIMIT_RESET     = 8'hFF;

  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_A12_EDGE  = 2'd1,
    ACT_CPU_TICK  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRG_LIMIT = 4'd0,
    CFG_CHR_LIMIT = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic [1:0]  prg_query_slot;
    logic [2:0]  chr_query_slot;
  } cbm_in_t;

  typedef struct packed {
    logic       irq_line;
    logic       mirror_horizontal;
    logic [7:0] prg_bank_out;
    logic [7:0] chr_bank_out;
    logic [7:0] irq_count_out;
    logic       irq_enable_out;
  } cbm_out_t;

  // Reduce a bank number above the limit by masking it with the limit.
  function automatic logic [BANK_W-1:0] clamp_bank(input logic [BANK_W-1:0] v,
                                                   input logic [BANK_W-1:0] limit);
    clamp_bank = (v > limit) ? (v & limit) : v;
  endfunction

endpackage

// File: design/cartridge_bank_mapper_with_scanline_irq.sv
// Cartridge bank mapper with bank clamping, mirroring and a scanline IRQ counter.
// The result of an accepted input beat appears on the output register in the next cycle.
// Throughput: one beat per cycle while out_stall_i is low; the output register lets a new beat in while the
// previous result is taken, and the stall path is a single AND of out_stall_i.
// Reset: async active low; bank, IRQ and mirror state clear to zero, both bank limits
// return to 255, and the output register empties.
module cartridge_bank_mapper_with_scanline_irq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cbm_pkg::cbm_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cbm_pkg::cbm_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  logic [7:0] prg_limit_q, chr_limit_q;
  logic [7:0] prg_bank_q [cbm_pkg::PRG_SLOTS];
  logic [7:0] prg_bank_d [cbm_pkg::PRG_SLOTS];
  logic [7:0] chr_bank_q [cbm_pkg::CHR_SLOTS];
  logic [7:0] chr_bank_d [cbm_pkg::CHR_SLOTS];
  logic [7:0] irq_reload_q, irq_reload_d;
  logic [7:0] irq_count_q, irq_count_d;
  logic       irq_enabled_q, irq_enabled_d;
  logic [1:0] irq_delay_q, irq_delay_d;
  logic       irq_pending_q, irq_pending_d;
  logic       mirror_q, mirror_d;

  logic               out_valid_q;
  cbm_pkg::cbm_out_t  out_q, out_d;
  logic               in_accept;
  logic [15:0]        addr;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign addr        = in_data_i.bus_address;

  always_comb begin
    prg_bank_d    = prg_bank_q;
    chr_bank_d    = chr_bank_q;
    irq_reload_d  = irq_reload_q;
    irq_count_d   = irq_count_q;
    irq_enabled_d = irq_enabled_q;
    irq_delay_d   = irq_delay_q;
    irq_pending_d = irq_pending_q;
    mirror_d      = mirror_q;

    case (cbm_pkg::action_e'(in_data_i.action))
      cbm_pkg::ACT_CPU_WRITE: begin
        if ((addr & ~cbm_pkg::ADDR_PRG_MASK) == cbm_pkg::ADDR_PRG_BASE) begin
          prg_bank_d[addr[1:0]] = cbm_pkg::clamp_bank(in_data_i.bus_data, prg_limit_q);
        end else if ((addr & ~cbm_pkg::ADDR_CHR_MASK) == cbm_pkg::ADDR_CHR_BASE) begin
          chr_bank_d[addr[2:0]] = cbm_pkg::clamp_bank(in_data_i.bus_data, chr_limit_q);
        end else if (addr == cbm_pkg::ADDR_IRQ_RELOAD) begin
          irq_reload_d = in_data_i.bus_data;
        end else if (addr == cbm_pkg::ADDR_IRQ_ACK) begin
          irq_pending_d = 1'b0;
        end else if (addr == cbm_pkg::ADDR_IRQ_LOAD) begin
          irq_count_d = irq_reload_q;
        end else if (addr == cbm_pkg::ADDR_MIRROR) begin
          mirror_d = in_data_i.bus_data[0];
        end else if (addr == cbm_pkg::ADDR_IRQ_EN) begin
          irq_enabled_d = in_data_i.bus_data[0];
        end
      end
      cbm_pkg::ACT_A12_EDGE: begin
        // step down; arm the delay when the count lands on zero
        if (irq_enabled_q && (irq_count_q != 8'd0)) begin
          irq_count_d = irq_count_q - 8'd1;
          if (irq_count_q == 8'd1) begin
            irq_delay_d = cbm_pkg::IRQ_DELAY_ARM;
          end
        end
      end
      cbm_pkg::ACT_CPU_TICK: begin
        if (irq_delay_q != 2'd0) begin
          irq_delay_d = irq_delay_q - 2'd1;
          if (irq_delay_q == 2'd1) begin
            irq_pending_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_d.irq_line          = irq_pending_d;
    out_d.mirror_horizontal = mirror_d;
    out_d.prg_bank_out      = prg_bank_d[in_data_i.prg_query_slot];
    out_d.chr_bank_out      = chr_bank_d[in_data_i.chr_query_slot];
    out_d.irq_count_out     = irq_count_d;
    out_d.irq_enable_out    = irq_enabled_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_limit_q <= cbm_pkg::LIMIT_RESET;
      chr_limit_q <= cbm_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cbm_pkg::cfg_idx_e'(cfg_index_i))
        cbm_pkg::CFG_PRG_LIMIT: prg_limit_q <= cfg_data_i;
        cbm_pkg::CFG_CHR_LIMIT: chr_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbm_pkg::PRG_SLOTS; i++) prg_bank_q[i] <= 8'd0;
      for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) chr_bank_q[i] <= 8'd0;
      irq_reload_q  <= 8'd0;
      irq_count_q   <= 8'd0;
      irq_enabled_q <= 1'b0;
      irq_delay_q   <= 2'd0;
      irq_pending_q <= 1'b0;
      mirror_q      <= 1'b0;
    end else if (in_accept) begin
      prg_bank_q    <= prg_bank_d;
      chr_bank_q    <= chr_bank_d;
      irq_reload_q  <= irq_reload_d;
      irq_count_q   <= irq_count_d;
      irq_enabled_q <= irq_enabled_d;
      irq_delay_q   <= irq_delay_d;
      irq_pending_q <= irq_pending_d;
      mirror_q      <= mirror_d;
    end
  end

  // Output register: load on every accepted beat, drain when not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  a_irq_rise_from_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_pending_q) |-> $past(in_accept && irq_delay_q == 2'd1
                                   && in_data_i.action == cbm_pkg::ACT_CPU_TICK))
    else $error("irq raised without delay expiry");

  a_count_steps_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.action == cbm_pkg::ACT_A12_EDGE && irq_enabled_q
     && irq_count_q != 8'd0) |=> (irq_count_q == $past(irq_count_q) - 8'd1))
    else $error("irq counter did not step down by one");

  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_delay_q != 2'd3)
    else $error("irq delay above arm value");

  a_out_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept))
    else $error("result beat appeared without an input beat");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the cartridge bank mapper: banks, clamping, mirroring, IRQ counter.
module tb;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BEATS = 73;
  localparam int          IN_W        = $bits(cbm_pkg::cbm_in_t);

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SCATTER,
    STALL_BURST
  } stall_mode_e;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  cbm_pkg::cbm_in_t              in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  cbm_pkg::cbm_out_t             out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]                    cfg_data_i  = '0;

  // Shadow copy of the mapper state and its limits
  logic [7:0] shadow_prg [cbm_pkg::PRG_SLOTS];
  logic [7:0] shadow_chr [cbm_pkg::CHR_SLOTS];
  logic [7:0] shadow_reload  = '0;
  logic [7:0] shadow_count   = '0;
  logic       shadow_irq_on  = 1'b0;
  logic [1:0] shadow_delay   = '0;
  logic       shadow_irq     = 1'b0;
  logic       shadow_mirror  = 1'b0;
  logic [7:0] shadow_prg_lim = cbm_pkg::LIMIT_RESET;
  logic [7:0] shadow_chr_lim = cbm_pkg::LIMIT_RESET;

  cbm_pkg::cbm_out_t bank_view_q [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned stall_run  = 0;

  cartridge_bank_mapper_with_scanline_irq i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Check result beats against the oldest expectation, then predict for the new input beat.
  always @(posedge clk_i) begin : scoreboard
    cbm_pkg::cbm_out_t want;
    logic [15:0]       addr;
    logic [7:0]        wdata;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (bank_view_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("unexpected result beat %h", out_data_o);
          end
        end else begin
          want = bank_view_q.pop_front();
          if (out_data_o !== want) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
              $display("mismatch exp/act: irq %0h/%0h mirror %0h/%0h prg %0h/%0h chr %0h/%0h",
                       want.irq_line, out_data_o.irq_line,
                       want.mirror_horizontal, out_data_o.mirror_horizontal,
                       want.prg_bank_out, out_data_o.prg_bank_out,
                       want.chr_bank_out, out_data_o.chr_bank_out);
              $display("  count %0h/%0h enable %0h/%0h",
                       want.irq_count_out, out_data_o.irq_count_out,
                       want.irq_enable_out, out_data_o.irq_enable_out);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cbm_pkg::CFG_PRG_LIMIT: shadow_prg_lim = cfg_data_i;
          cbm_pkg::CFG_CHR_LIMIT: shadow_chr_lim = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        addr  = in_data_i.bus_address;
        wdata = in_data_i.bus_data;
        case (in_data_i.action)
          cbm_pkg::ACT_CPU_WRITE: begin
            if ((addr & ~cbm_pkg::ADDR_PRG_MASK) == cbm_pkg::ADDR_PRG_BASE) begin
              shadow_prg[addr[1:0]] = (wdata > shadow_prg_lim) ? (wdata & shadow_prg_lim)
                                                               : wdata;
            end else if ((addr & ~cbm_pkg::ADDR_CHR_MASK) == cbm_pkg::ADDR_CHR_BASE) begin
              shadow_chr[addr[2:0]] = (wdata > shadow_chr_lim) ? (wdata & shadow_chr_lim)
                                                               : wdata;
            end else if (addr == cbm_pkg::ADDR_IRQ_RELOAD) begin
              shadow_reload = wdata;
            end else if (addr == cbm_pkg::ADDR_IRQ_ACK) begin
              shadow_irq = 1'b0;
            end else if (addr == cbm_pkg::ADDR_IRQ_LOAD) begin
              shadow_count = shadow_reload;
            end else if (addr == cbm_pkg::ADDR_MIRROR) begin
              shadow_mirror = wdata[0];
            end else if (addr == cbm_pkg::ADDR_IRQ_EN) begin
              shadow_irq_on = wdata[0];
            end
          end
          cbm_pkg::ACT_A12_EDGE: begin
            // Count down only while enabled and nonzero; re-arm the delay on reaching zero
            if (shadow_irq_on && shadow_count != 0) begin
              shadow_count--;
              if (shadow_count == 0) shadow_delay = cbm_pkg::IRQ_DELAY_ARM;
            end
          end
          cbm_pkg::ACT_CPU_TICK: begin
            if (shadow_delay != 0) begin
              shadow_delay--;
              if (shadow_delay == 0) shadow_irq = 1'b1;
            end
          end
          default: ;
        endcase
        want.irq_line          = shadow_irq;
        want.mirror_horizontal = shadow_mirror;
        want.prg_bank_out      = shadow_prg[in_data_i.prg_query_slot];
        want.chr_bank_out      = shadow_chr[in_data_i.chr_query_slot];
        want.irq_count_out     = shadow_count;
        want.irq_enable_out    = shadow_irq_on;
        bank_view_q.push_back(want);
      end
    end
  end

  // Receiver: switch between no stall, scattered stalls and stall runs.
  always @(negedge clk_i) begin : stall_pattern
    logic stall_next;
    if (mode_left == 0) begin
      case ($urandom_range(0, 2))
        0: stall_mode = STALL_NONE;
        1: stall_mode = STALL_SCATTER;
        default: stall_mode = STALL_BURST;
      endcase
      mode_left = $urandom_range(20, 80);
    end
    mode_left--;
    stall_next = 1'b0;
    case (stall_mode)
      STALL_SCATTER: stall_next = ($urandom_range(0, 2) == 0);
      STALL_BURST: begin
        if (stall_run == 0 && $urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 8);
        if (stall_run != 0) begin
          stall_next = 1'b1;
          stall_run--;
        end
      end
      default: ;
    endcase
    out_stall_i <= stall_next;
  end

  function automatic cbm_pkg::cbm_in_t mk_beat(input logic [1:0] act,
                                               input logic [15:0] addr,
                                               input logic [7:0] data);
    cbm_pkg::cbm_in_t b;
    b.action         = act;
    b.bus_address    = addr;
    b.bus_data       = data;
    // Often query the slot the address points at, so bank writes show up at once
    b.prg_query_slot = ($urandom_range(0, 1) != 0) ? addr[1:0] : 2'($urandom);
    b.chr_query_slot = ($urandom_range(0, 1) != 0) ? addr[2:0] : 3'($urandom);
    return b;
  endfunction

  function automatic cbm_pkg::cbm_in_t random_beat();
    int unsigned pick;
    logic [1:0]  act;
    logic [15:0] addr;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    act  = cbm_pkg::ACT_CPU_WRITE;
    addr = 16'($urandom);
    data = 8'($urandom);
    if (pick < 30) begin
      act = cbm_pkg::ACT_A12_EDGE;
    end else if (pick < 55) begin
      act = cbm_pkg::ACT_CPU_TICK;
    end else if (pick < 59) begin
      act = ACT_UNUSED;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: addr = cbm_pkg::ADDR_PRG_BASE | (16'($urandom) & cbm_pkg::ADDR_PRG_MASK);
        2, 3: addr = cbm_pkg::ADDR_CHR_BASE | (16'($urandom) & cbm_pkg::ADDR_CHR_MASK);
        4: begin
          addr = cbm_pkg::ADDR_IRQ_RELOAD;
          // Keep reload values small so the counter reaches zero often
          if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(1, 4));
        end
        5: addr = cbm_pkg::ADDR_IRQ_ACK;
        6: addr = cbm_pkg::ADDR_IRQ_LOAD;
        7: addr = cbm_pkg::ADDR_MIRROR;
        8: begin
          addr    = cbm_pkg::ADDR_IRQ_EN;
          data[0] = ($urandom_range(0, 3) != 0);
        end
        default: begin
          if ($urandom_range(0, 1) != 0) addr[15:13] = cbm_pkg::ADDR_IRQ_ACK[15:13];
        end
      endcase
    end
    return mk_beat(act, addr, data);
  endfunction

  // Send one beat; open a random gap whenever the current burst runs out.
  task automatic drive_beat(input cbm_pkg::cbm_in_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) begin
          in_data_i = IN_W'($urandom);
          @(negedge clk_i);
        end
      end
      burst_left = $urandom_range(1, 16);
    end
    in_data_i  = beat;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Hold off input until every expected result has come, then let the pipeline empty.
  task automatic settle_mapper();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (bank_view_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_limits(input logic [7:0] prg_lim, input logic [7:0] chr_lim,
                              input bit poke_unused);
    logic [cbm_pkg::CFG_IDX_W-1:0] idx [3];
    logic [7:0]                    val [3];
    int                            n;
    settle_mapper();
    idx[0] = cbm_pkg::CFG_PRG_LIMIT;
    val[0] = prg_lim;
    idx[1] = cbm_pkg::CFG_CHR_LIMIT;
    val[1] = chr_lim;
    idx[2] = cbm_pkg::CFG_IDX_W'($urandom_range(cbm_pkg::CFG_CHR_LIMIT + 1,
                                                (1 << cbm_pkg::CFG_IDX_W) - 1));
    val[2] = 8'($urandom);
    n = poke_unused ? 3 : 2;
    cfg_valid_i = 1'b1;
    for (int k = 0; k < n; k++) begin
      cfg_index_i = idx[k];
      cfg_data_i  = val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_reset_view();
    drive_beat(mk_beat(ACT_UNUSED, 16'($urandom), 8'($urandom)));
  endtask

  task automatic test_bank_extremes();
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_PRG_BASE, 8'hFF));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE,
                       cbm_pkg::ADDR_PRG_BASE | cbm_pkg::ADDR_PRG_MASK, 8'h00));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE,
                       cbm_pkg::ADDR_CHR_BASE | cbm_pkg::ADDR_CHR_MASK, 8'hFF));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_CHR_BASE, 8'h80));
  endtask

  task automatic test_bank_clamp();
    write_limits(8'h0F, 8'h00, 1'b0);
    // At the limit: unchanged; above it: masked
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_PRG_BASE + 16'd1, 8'h0F));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_PRG_BASE + 16'd2, 8'hF3));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_CHR_BASE + 16'd5, 8'h55));
  endtask

  task automatic test_decode_misses();
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_PRG_BASE + 16'd4, 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_CHR_BASE + 16'd8, 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_RELOAD - 16'd1,
                       8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, 16'hFFFF, 8'($urandom)));
  endtask

  task automatic test_mirror();
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_MIRROR, 8'hFF));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_MIRROR, 8'hFE));
  endtask

  task automatic test_irq_sequence();
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_RELOAD, 8'h01));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_LOAD, 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_EN, 8'h01));
    drive_beat(mk_beat(cbm_pkg::ACT_A12_EDGE, 16'($urandom), 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_TICK, 16'($urandom), 8'($urandom)));
    // Reach zero again while the delay is still running
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_LOAD, 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_A12_EDGE, 16'($urandom), 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_A12_EDGE, 16'($urandom), 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_TICK, 16'($urandom), 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_TICK, 16'($urandom), 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_ACK, 8'($urandom)));
    // Edge while disabled must not count
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_EN, 8'hFE));
    drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_LOAD, 8'($urandom)));
    drive_beat(mk_beat(cbm_pkg::ACT_A12_EDGE, 16'($urandom), 8'($urandom)));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_limits(8'hFF, 8'h00, 1'b0);
        1: write_limits(8'h00, 8'hFF, 1'b1);
        PHASES - 1: write_limits(8'hFF, 8'hFF, 1'b0);
        default: write_limits(8'($urandom), 8'($urandom), 1'b0);
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 2 && n == PHASE_BEATS / 2) settle_mapper();
        // Arm a fresh countdown now and then so the IRQ path gets exercised
        if ($urandom_range(0, 15) == 0) begin
          drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_RELOAD,
                             8'($urandom_range(1, 4))));
          drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_LOAD, 8'($urandom)));
          drive_beat(mk_beat(cbm_pkg::ACT_CPU_WRITE, cbm_pkg::ADDR_IRQ_EN, 8'h01));
        end
        drive_beat(random_beat());
      end
    end
  endtask

  initial begin
    for (int k = 0; k < cbm_pkg::PRG_SLOTS; k++) shadow_prg[k] = '0;
    for (int k = 0; k < cbm_pkg::CHR_SLOTS; k++) shadow_chr[k] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_view();
    test_bank_extremes();
    test_bank_clamp();
    test_decode_misses();
    test_mirror();
    test_irq_sequence();
    test_random_traffic();
    settle_mapper();
    if (fail_count == 0 && bank_view_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/cbm_pkg.sv
design/cartridge_bank_mapper_with_scanline_irq.sv
sim/tb.sv
